@@ hw/rtl/rptb_pkg.sv @@
// ----------------------------------------------------------------------------
// rptb_pkg
// Shared types and constants of the relay pattern timer bank.
// ----------------------------------------------------------------------------
package rptb_pkg;

    localparam int COUNT_WIDTH_DEF = 16;

    localparam int BANK_TIMERS = 5;
    localparam int SEL_W       = 3;
    localparam int CFG_W       = 16;
    localparam int BURST_W     = 4;
    localparam int VALUE_W     = 16;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    // Timer indexes
    localparam logic [SEL_W-1:0] T_BLINK     = 3'd0;
    localparam logic [SEL_W-1:0] T_RELAY_ON  = 3'd1;
    localparam logic [SEL_W-1:0] T_RELAY_OFF = 3'd2;
    localparam logic [SEL_W-1:0] T_PAT_REL   = 3'd3;
    localparam logic [SEL_W-1:0] T_PAT_DRV   = 3'd4;
    localparam logic [SEL_W-1:0] T_LAST      = 3'd4;

    // Register indexes
    localparam logic [2:0] REG_BLINK_PERIOD   = 3'd0;
    localparam logic [2:0] REG_RELAY_ON_TIME  = 3'd1;
    localparam logic [2:0] REG_RELAY_OFF_TIME = 3'd2;
    localparam logic [2:0] REG_PATTERN_GAP    = 3'd3;
    localparam logic [2:0] REG_PATTERN_PULSE  = 3'd4;
    localparam logic [2:0] REG_PATTERN_BURST  = 3'd5;

    // Register reset values
    localparam logic [CFG_W-1:0]   RST_BLINK_PERIOD   = 16'd500;
    localparam logic [CFG_W-1:0]   RST_RELAY_ON_TIME  = 16'd15000;
    localparam logic [CFG_W-1:0]   RST_RELAY_OFF_TIME = 16'd5000;
    localparam logic [CFG_W-1:0]   RST_PATTERN_GAP    = 16'd5000;
    localparam logic [CFG_W-1:0]   RST_PATTERN_PULSE  = 16'd500;
    localparam logic [BURST_W-1:0] RST_PATTERN_BURST  = 4'd9;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_RESET = 2'd2,
        CMD_STOP  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [CFG_W-1:0]   blink_period;
        logic [CFG_W-1:0]   relay_on_time;
        logic [CFG_W-1:0]   relay_off_time;
        logic [CFG_W-1:0]   pattern_gap;
        logic [CFG_W-1:0]   pattern_pulse;
        logic [BURST_W-1:0] pattern_burst;
    } cfg_t;

    typedef struct packed {
        logic                   led_level;
        logic                   relay_on;
        logic                   pattern_released;
        logic [BANK_TIMERS-1:0] expired_mask;
        logic                   bad_index;
    } result_t;

    typedef struct packed {
        logic active;
        logic fired;
    } dec_status_t;

endpackage

@@ hw/rtl/rptb_if.sv @@
// ----------------------------------------------------------------------------
// rptb_cmd_if / rptb_res_if
// Valid/ready channels for commands into and results out of the timer bank.
// ----------------------------------------------------------------------------
interface rptb_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    cmd;
    logic [rptb_pkg::SEL_W-1:0]    timer_sel;
    logic [rptb_pkg::VALUE_W-1:0]  load_value;

    modport source (output valid, output cmd, output timer_sel, output load_value,
                    input ready);
    modport sink   (input valid, input cmd, input timer_sel, input load_value,
                    output ready);
endinterface

interface rptb_res_if;
    logic                              valid;
    logic                              ready;
    logic                              led_level;
    logic                              relay_on;
    logic                              pattern_released;
    logic [rptb_pkg::BANK_TIMERS-1:0]  expired_mask;
    logic                              bad_index;

    modport source (output valid, output led_level, output relay_on,
                    output pattern_released, output expired_mask, output bad_index,
                    input ready);
    modport sink   (input valid, input led_level, input relay_on,
                    input pattern_released, input expired_mask, input bad_index,
                    output ready);
endinterface

@@ hw/rtl/rptb_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// rptb_cfg_regs
// APB register file holding the reload periods and the pattern burst count.
// ----------------------------------------------------------------------------
module rptb_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rptb_pkg::ADDR_W-1:0]   paddr,
    input  logic [rptb_pkg::DATA_W-1:0]   pwdata,
    output logic [rptb_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output rptb_pkg::cfg_t                cfg
);

    rptb_pkg::cfg_t cfg_reg;
    rptb_pkg::cfg_t cfg_next;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[rptb_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                rptb_pkg::REG_BLINK_PERIOD:   cfg_next.blink_period   = pwdata[15:0];
                rptb_pkg::REG_RELAY_ON_TIME:  cfg_next.relay_on_time  = pwdata[15:0];
                rptb_pkg::REG_RELAY_OFF_TIME: cfg_next.relay_off_time = pwdata[15:0];
                rptb_pkg::REG_PATTERN_GAP:    cfg_next.pattern_gap    = pwdata[15:0];
                rptb_pkg::REG_PATTERN_PULSE:  cfg_next.pattern_pulse  = pwdata[15:0];
                rptb_pkg::REG_PATTERN_BURST:  cfg_next.pattern_burst  = pwdata[3:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            rptb_pkg::REG_BLINK_PERIOD:   prdata = {16'd0, cfg_reg.blink_period};
            rptb_pkg::REG_RELAY_ON_TIME:  prdata = {16'd0, cfg_reg.relay_on_time};
            rptb_pkg::REG_RELAY_OFF_TIME: prdata = {16'd0, cfg_reg.relay_off_time};
            rptb_pkg::REG_PATTERN_GAP:    prdata = {16'd0, cfg_reg.pattern_gap};
            rptb_pkg::REG_PATTERN_PULSE:  prdata = {16'd0, cfg_reg.pattern_pulse};
            rptb_pkg::REG_PATTERN_BURST:  prdata = {28'd0, cfg_reg.pattern_burst};
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blink_period   <= rptb_pkg::RST_BLINK_PERIOD;
            cfg_reg.relay_on_time  <= rptb_pkg::RST_RELAY_ON_TIME;
            cfg_reg.relay_off_time <= rptb_pkg::RST_RELAY_OFF_TIME;
            cfg_reg.pattern_gap    <= rptb_pkg::RST_PATTERN_GAP;
            cfg_reg.pattern_pulse  <= rptb_pkg::RST_PATTERN_PULSE;
            cfg_reg.pattern_burst  <= rptb_pkg::RST_PATTERN_BURST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hw/rtl/rptb_dec_unit.sv @@
// ----------------------------------------------------------------------------
// rptb_dec_unit
// Shared decrement and zero-detect unit, used once per visited timer.
// ----------------------------------------------------------------------------
module rptb_dec_unit #(
    parameter int COUNT_WIDTH = rptb_pkg::COUNT_WIDTH_DEF
) (
    input  logic [COUNT_WIDTH-1:0] count,
    output logic [COUNT_WIDTH-1:0] count_dec,
    output rptb_pkg::dec_status_t  status
);

    assign count_dec     = count - COUNT_WIDTH'(1);
    assign status.active = |count;
    // A running timer fires on the visit that brings it down to zero.
    assign status.fired  = (|count) && (count_dec == '0);

endmodule

@@ hw/rtl/rptb_bank.sv @@
// ----------------------------------------------------------------------------
// rptb_bank
// Timer state and the sequencer that executes commands and walks the timers.
// ----------------------------------------------------------------------------
module rptb_bank #(
    parameter int COUNT_WIDTH = rptb_pkg::COUNT_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rptb_pkg::cfg_t     cfg,
    rptb_cmd_if.sink           cmd_ch,
    input  logic               slot_free,
    output logic               emit,
    output rptb_pkg::result_t  result
);

    localparam int NT = rptb_pkg::BANK_TIMERS;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EXEC  = 4'b0010,
        ST_VISIT = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [COUNT_WIDTH-1:0]          cnt_reg [NT];
    logic [COUNT_WIDTH-1:0]          cnt_next [NT];
    logic [COUNT_WIDTH-1:0]          rld_reg [NT];
    logic [COUNT_WIDTH-1:0]          rld_next [NT];
    logic [rptb_pkg::BURST_W-1:0]    pulses_reg, pulses_next;
    logic                            led_reg, led_next;
    logic                            relay_reg, relay_next;
    logic                            pat_reg, pat_next;
    logic [rptb_pkg::SEL_W-1:0]      idx_reg, idx_next;
    logic [NT-1:0]                   mask_reg, mask_next;
    logic                            bad_reg, bad_next;
    rptb_pkg::cmd_t                  cmd_reg, cmd_next;
    logic [rptb_pkg::SEL_W-1:0]      sel_reg, sel_next;
    logic [rptb_pkg::VALUE_W-1:0]    val_reg, val_next;

    logic [COUNT_WIDTH-1:0]          dec_in;
    logic [COUNT_WIDTH-1:0]          dec_out;
    rptb_pkg::dec_status_t           dec_st;
    logic                            accept;

    assign cmd_ch.ready = (state_reg == ST_IDLE);
    assign accept       = cmd_ch.valid && cmd_ch.ready;
    assign dec_in       = cnt_reg[idx_reg];

    rptb_dec_unit #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dec (
        .count     (dec_in),
        .count_dec (dec_out),
        .status    (dec_st)
    );

    assign emit                    = (state_reg == ST_EMIT) && slot_free;
    assign result.led_level        = led_reg;
    assign result.relay_on         = relay_reg;
    assign result.pattern_released = pat_reg;
    assign result.expired_mask     = mask_reg;
    assign result.bad_index        = bad_reg;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        rld_next    = rld_reg;
        pulses_next = pulses_reg;
        led_next    = led_reg;
        relay_next  = relay_reg;
        pat_next    = pat_reg;
        idx_next    = idx_reg;
        mask_next   = mask_reg;
        bad_next    = bad_reg;
        cmd_next    = cmd_reg;
        sel_next    = sel_reg;
        val_next    = val_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = rptb_pkg::cmd_t'(cmd_ch.cmd);
                    sel_next  = cmd_ch.timer_sel;
                    val_next  = cmd_ch.load_value;
                    mask_next = '0;
                    bad_next  = 1'b0;
                    idx_next  = '0;
                    if (rptb_pkg::cmd_t'(cmd_ch.cmd) == rptb_pkg::CMD_TICK)
                        state_next = ST_VISIT;
                    else
                        state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (sel_reg > rptb_pkg::T_LAST)
                begin
                    bad_next = 1'b1;
                end
                else
                begin
                    unique case (cmd_reg)
                        rptb_pkg::CMD_SET:
                        begin
                            cnt_next[sel_reg] = COUNT_WIDTH'(val_reg);
                            rld_next[sel_reg] = COUNT_WIDTH'(val_reg);
                        end
                        rptb_pkg::CMD_RESET: cnt_next[sel_reg] = rld_reg[sel_reg];
                        rptb_pkg::CMD_STOP:  cnt_next[sel_reg] = '0;
                        rptb_pkg::CMD_TICK:  cnt_next = cnt_reg;
                    endcase
                end
                state_next = ST_EMIT;
            end

            ST_VISIT:
            begin
                if (dec_st.active)
                    cnt_next[idx_reg] = dec_out;
                // Actions are applied after the decrement, so a reload of the
                // visited timer itself wins, and loads of later timers are seen
                // by their own visit in this tick.
                if (dec_st.fired)
                begin
                    mask_next[idx_reg] = 1'b1;
                    case (idx_reg)
                        rptb_pkg::T_BLINK:
                        begin
                            led_next = !led_reg;
                            cnt_next[rptb_pkg::T_BLINK] = COUNT_WIDTH'(cfg.blink_period);
                            rld_next[rptb_pkg::T_BLINK] = COUNT_WIDTH'(cfg.blink_period);
                        end
                        rptb_pkg::T_RELAY_ON:
                        begin
                            relay_next  = 1'b1;
                            pulses_next = cfg.pattern_burst;
                            cnt_next[rptb_pkg::T_RELAY_OFF] = COUNT_WIDTH'(cfg.relay_on_time);
                            rld_next[rptb_pkg::T_RELAY_OFF] = COUNT_WIDTH'(cfg.relay_on_time);
                            cnt_next[rptb_pkg::T_PAT_DRV]   = COUNT_WIDTH'(cfg.pattern_gap);
                            rld_next[rptb_pkg::T_PAT_DRV]   = COUNT_WIDTH'(cfg.pattern_gap);
                        end
                        rptb_pkg::T_RELAY_OFF:
                        begin
                            relay_next = 1'b0;
                            cnt_next[rptb_pkg::T_RELAY_ON] = COUNT_WIDTH'(cfg.relay_off_time);
                            rld_next[rptb_pkg::T_RELAY_ON] = COUNT_WIDTH'(cfg.relay_off_time);
                        end
                        rptb_pkg::T_PAT_REL:
                        begin
                            pat_next = 1'b1;
                            if (pulses_reg != '0)
                            begin
                                pulses_next = pulses_reg - 4'd1;
                                if (pulses_reg != 4'd1)
                                begin
                                    cnt_next[rptb_pkg::T_PAT_DRV] =
                                        COUNT_WIDTH'(cfg.pattern_gap);
                                    rld_next[rptb_pkg::T_PAT_DRV] =
                                        COUNT_WIDTH'(cfg.pattern_gap);
                                end
                            end
                        end
                        default:
                        begin
                            pat_next = 1'b0;
                            cnt_next[rptb_pkg::T_PAT_REL] = COUNT_WIDTH'(cfg.pattern_pulse);
                            rld_next[rptb_pkg::T_PAT_REL] = COUNT_WIDTH'(cfg.pattern_pulse);
                        end
                    endcase
                end
                if (idx_reg == rptb_pkg::T_LAST)
                    state_next = ST_EMIT;
                else
                    idx_next = idx_reg + 3'd1;
            end

            ST_EMIT:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            for (int i = 0; i < NT; i++)
            begin
                cnt_reg[i] <= '0;
                rld_reg[i] <= '0;
            end
            pulses_reg <= '0;
            led_reg    <= 1'b0;
            relay_reg  <= 1'b0;
            pat_reg    <= 1'b0;
            idx_reg    <= '0;
            mask_reg   <= '0;
            bad_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rld_reg    <= rld_next;
            pulses_reg <= pulses_next;
            led_reg    <= led_next;
            relay_reg  <= relay_next;
            pat_reg    <= pat_next;
            idx_reg    <= idx_next;
            mask_reg   <= mask_next;
            bad_reg    <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        sel_reg <= sel_next;
        val_reg <= val_next;
    end

endmodule

@@ hw/rtl/relay_pattern_timer_bank_core.sv @@
// ----------------------------------------------------------------------------
// relay_pattern_timer_bank_core
// Five reloadable down-counting timers driving LED, relay and pattern pins.
// ----------------------------------------------------------------------------
// A tick runs from the accept state through one visit per timer in the shared
// decrement unit to the emit state; set, reset and stop go through the execute
// state to the emit state. Emit waits while the output register is occupied, and
// no command is taken until then. The result is held in an output register.
// Reset clears all counters, reloads and pin levels and loads the register
// defaults; the block is ready in the first cycle after reset is released.
module relay_pattern_timer_bank_core #(
    parameter int COUNT_WIDTH = rptb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rptb_pkg::ADDR_W-1:0]   paddr,
    input  logic [rptb_pkg::DATA_W-1:0]   pwdata,
    output logic [rptb_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    rptb_cmd_if.sink                      cmd_ch,
    rptb_res_if.source                    res_ch
);

    rptb_pkg::cfg_t    cfg;
    rptb_pkg::result_t result;
    rptb_pkg::result_t res_reg;
    logic              emit;
    logic              slot_free;
    logic              out_valid_reg;

    rptb_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rptb_bank #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_bank (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_ch    (cmd_ch),
        .slot_free (slot_free),
        .emit      (emit),
        .result    (result)
    );

    // The output register can take a new result when it is empty or being drained.
    assign slot_free = !out_valid_reg || res_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            res_reg <= result;
    end

    assign res_ch.valid            = out_valid_reg;
    assign res_ch.led_level        = res_reg.led_level;
    assign res_ch.relay_on         = res_reg.relay_on;
    assign res_ch.pattern_released = res_reg.pattern_released;
    assign res_ch.expired_mask     = res_reg.expired_mask;
    assign res_ch.bad_index        = res_reg.bad_index;

`ifndef SYNTHESIS
    a_emit_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> slot_free)
        else $error("result emitted while the output register is occupied");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> res_ch.valid)
        else $error("emitted result not presented on the result channel");

    a_no_busy_accept: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !cmd_ch.ready)
        else $error("command channel ready while a result is being emitted");

    a_bad_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
        res_ch.valid |-> !(res_ch.bad_index && (res_ch.expired_mask != '0)))
        else $error("result reports a bad index and expired timers together");
`endif

endmodule
